/* rtl/irfe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// irfe_pkg - shared definitions for the IR frame timing encoder
// Protocol codes, timing constants in microseconds, sequencer states and
// the pair word passed from the sequencer to the output register.
// ----------------------------------------------------------------------------
package irfe_pkg;

  localparam int DUR_W  = 14;   // duration field width
  localparam int RUN_W  = 11;   // RC5 run length (two halves at most)
  localparam int BITS_W = 32;   // frame bit shift register
  localparam int CNT_W  = 5;    // bit position counter
  localparam int PROTO_W = 2;
  localparam int RC5_BITS = 14;

  localparam logic [PROTO_W-1:0] PROTO_NEC  = 2'd0;
  localparam logic [PROTO_W-1:0] PROTO_SIRC = 2'd1;
  localparam logic [PROTO_W-1:0] PROTO_RC5  = 2'd2;
  localparam logic [PROTO_W-1:0] PROTO_NONE = 2'd3;

  localparam logic [DUR_W-1:0] T_NEC_HDR_MARK  = 14'd9000;
  localparam logic [DUR_W-1:0] T_NEC_HDR_SPACE = 14'd4500;
  localparam logic [DUR_W-1:0] T_NEC_SHORT     = 14'd562;
  localparam logic [DUR_W-1:0] T_NEC_LONG      = 14'd1687;
  localparam logic [DUR_W-1:0] T_SIRC_HDR      = 14'd2400;
  localparam logic [DUR_W-1:0] T_SIRC_UNIT     = 14'd600;
  localparam logic [DUR_W-1:0] T_SIRC_ONE      = 14'd1200;
  localparam logic [DUR_W-1:0] T_GAP           = 14'd10000;
  localparam logic [DUR_W-1:0] T_ZERO          = 14'd0;
  localparam logic [RUN_W-1:0] T_RC5_HALF      = 11'd889;

  localparam logic [CNT_W-1:0] NEC_LAST_BIT  = 5'd31;
  localparam logic [CNT_W-1:0] SIRC_LAST_BIT = 5'd11;
  localparam logic [CNT_W-1:0] RC5_LAST_BIT  = 5'd13;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_BITS,
    S_TAIL,
    S_RC5_RUN,
    S_RC5_END
  } state_t;

  typedef struct packed {
    logic [DUR_W-1:0] mark;
    logic [DUR_W-1:0] space;
    logic             last;
  } pair_t;

endpackage
`default_nettype wire

/* rtl/irfe_out_buf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// irfe_out_buf - output pair register
// Holds one finished pair until the consumer takes it; frees the sequencer
// as soon as the held word leaves.
// ----------------------------------------------------------------------------
module irfe_out_buf
  import irfe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  input  wire pair_t            push_pair,
  output logic                  push_ready,
  output logic                  pair_valid,
  input  wire logic             pair_ready,
  output logic [DUR_W-1:0]      mark_us,
  output logic [DUR_W-1:0]      space_us,
  output logic                  last
);

  logic  valid;
  pair_t data;

  assign push_ready = !valid || pair_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push_ready) begin
      valid <= push_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (push_ready && push_valid) begin
      data <= push_pair;
    end
  end

  assign pair_valid = valid;
  assign mark_us    = data.mark;
  assign space_us   = data.space;
  assign last       = data.last;

endmodule
`default_nettype wire

/* rtl/irfe_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// irfe_seq - frame sequencer
// Walks the frame bits one position per step, selects pair timings for NEC
// and SIRC, and merges RC5 Manchester halves into runs with one adder.
// ----------------------------------------------------------------------------
module irfe_seq
  import irfe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [PROTO_W-1:0] protocol,
  input  wire logic [15:0]        address,
  input  wire logic [7:0]         command,
  output logic                    idle,
  output logic                    push_valid,
  output pair_t                   push_pair,
  input  wire logic               push_ready
);

  state_t               state, state_next;
  logic [BITS_W-1:0]    frame_bits, frame_bits_next;
  logic [CNT_W-1:0]     bit_cnt, bit_cnt_next;
  logic                 phase, phase_next;
  logic                 run_level, run_level_next;
  logic [RUN_W-1:0]     run_length, run_length_next;
  logic [DUR_W-1:0]     mark_hold, mark_hold_next;
  logic [PROTO_W-1:0]   proto, proto_next;

  logic [RC5_BITS-1:0]  rc5_word;
  logic [RC5_BITS-1:0]  rc5_rev;
  logic [BITS_W-1:0]    load_bits;
  logic                 is_nec;
  logic                 cur_bit;
  logic                 half_lv;
  logic                 run_change;
  logic [RUN_W-1:0]     run_sum;
  logic                 rc5_done;
  logic                 rc5_adv;
  logic [CNT_W-1:0]     last_bit;
  logic [DUR_W-1:0]     run_ext;

  assign is_nec     = (proto == PROTO_NEC);
  assign cur_bit    = frame_bits[0];
  // Manchester: a one is space then mark, a zero is mark then space
  assign half_lv    = phase ? cur_bit : ~cur_bit;
  assign run_change = (half_lv != run_level);
  assign run_sum    = run_length + T_RC5_HALF;
  assign rc5_done   = phase && (bit_cnt == RC5_LAST_BIT);
  assign rc5_adv    = !(push_valid && !push_ready);
  assign last_bit   = is_nec ? NEC_LAST_BIT : SIRC_LAST_BIT;
  assign run_ext    = {{(DUR_W-RUN_W){1'b0}}, run_length};
  assign idle       = (state == S_IDLE);

  // RC5 is sent MSB first: load it reversed so every scheme shifts right
  always_comb begin
    rc5_word = {2'b11, 1'b0, address[4:0], command[5:0]};
    for (int i = 0; i < RC5_BITS; i++) begin
      rc5_rev[i] = rc5_word[RC5_BITS-1-i];
    end
  end

  always_comb begin
    unique case (protocol)
      PROTO_NEC:  load_bits = {~command, command, address};
      PROTO_SIRC: load_bits = {20'd0, address[4:0], command[6:0]};
      PROTO_RC5:  load_bits = {{(BITS_W-RC5_BITS){1'b0}}, rc5_rev};
      default:    load_bits = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (protocol == PROTO_RC5) ? S_RC5_RUN : S_HEAD;
        end
      end
      S_HEAD: begin
        if (push_ready) begin
          state_next = S_BITS;
        end
      end
      S_BITS: begin
        if (push_ready && bit_cnt == last_bit) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        if (push_ready) begin
          state_next = S_IDLE;
        end
      end
      S_RC5_RUN: begin
        if (rc5_adv && rc5_done) begin
          state_next = S_RC5_END;
        end
      end
      S_RC5_END: begin
        if (push_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    push_valid = 1'b0;
    push_pair  = '0;
    unique case (state)
      S_IDLE: begin
        push_valid = 1'b0;
      end
      S_HEAD: begin
        push_valid      = 1'b1;
        push_pair.mark  = is_nec ? T_NEC_HDR_MARK : T_SIRC_HDR;
        push_pair.space = is_nec ? T_NEC_HDR_SPACE : T_SIRC_UNIT;
      end
      S_BITS: begin
        push_valid = 1'b1;
        if (is_nec) begin
          push_pair.mark  = T_NEC_SHORT;
          push_pair.space = cur_bit ? T_NEC_LONG : T_NEC_SHORT;
        end else begin
          push_pair.mark  = cur_bit ? T_SIRC_ONE : T_SIRC_UNIT;
          push_pair.space = T_SIRC_UNIT;
        end
      end
      S_TAIL: begin
        push_valid      = 1'b1;
        push_pair.mark  = is_nec ? T_NEC_SHORT : T_ZERO;
        push_pair.space = T_GAP;
        push_pair.last  = 1'b1;
      end
      S_RC5_RUN: begin
        // a space run closing completes the pair begun by the held mark
        push_valid      = run_change && !run_level;
        push_pair.mark  = mark_hold;
        push_pair.space = run_ext;
      end
      S_RC5_END: begin
        push_valid      = 1'b1;
        push_pair.mark  = run_level ? run_ext : mark_hold;
        push_pair.space = run_level ? T_GAP : run_ext;
        push_pair.last  = 1'b1;
      end
      default: push_valid = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    frame_bits_next = frame_bits;
    bit_cnt_next    = bit_cnt;
    phase_next      = phase;
    run_level_next  = run_level;
    run_length_next = run_length;
    mark_hold_next  = mark_hold;
    proto_next      = proto;
    case (state)
      S_IDLE: begin
        if (start) begin
          frame_bits_next = load_bits;
          bit_cnt_next    = '0;
          phase_next      = 1'b1;   // drop the leading idle half of RC5
          run_level_next  = 1'b1;
          run_length_next = '0;
          proto_next      = protocol;
        end
      end
      S_BITS: begin
        if (push_ready) begin
          frame_bits_next = frame_bits >> 1;
          bit_cnt_next    = bit_cnt + 1'b1;
        end
      end
      S_RC5_RUN: begin
        if (rc5_adv) begin
          if (run_change) begin
            if (run_level) begin
              mark_hold_next = run_ext;
            end
            run_length_next = T_RC5_HALF;
            run_level_next  = half_lv;
          end else begin
            run_length_next = run_sum;
          end
          if (phase) begin
            phase_next      = 1'b0;
            frame_bits_next = frame_bits >> 1;
            bit_cnt_next    = bit_cnt + 1'b1;
          end else begin
            phase_next = 1'b1;
          end
        end
      end
      default: begin
        proto_next = proto;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bit_cnt    <= '0;
      phase      <= 1'b0;
      run_level  <= 1'b1;
      run_length <= '0;
      proto      <= PROTO_NEC;
    end else begin
      state      <= state_next;
      bit_cnt    <= bit_cnt_next;
      phase      <= phase_next;
      run_level  <= run_level_next;
      run_length <= run_length_next;
      proto      <= proto_next;
    end
  end

  always_ff @(posedge clk) begin
    frame_bits <= frame_bits_next;
    mark_hold  <= mark_hold_next;
  end

endmodule
`default_nettype wire

/* rtl/ir_remote_frame_timing_encoder.sv */
`default_nettype none
// The first NEC or SIRC pair passes from the sequencer's header state through
// the output register; the first RC5 pair waits until its mark and space runs close.
// Throughput: one pair per cycle for NEC and SIRC while the receiver takes every
// pair; RC5 takes one cycle per Manchester half unless a pushed pair is stalled.
// The sequencer walks one bit or half per step and holds off the next word.
// Reset (rst, synchronous): sequencer idle, output empty, protocol NEC.
// ----------------------------------------------------------------------------
// ir_remote_frame_timing_encoder - IR remote frame timing encoder
// Turns one address/command word into the mark/space pairs of an NEC,
// SIRC-12 or RC5 frame, selected by the protocol register.
// ----------------------------------------------------------------------------
module ir_remote_frame_timing_encoder
  import irfe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // protocol register write
  input  wire logic               protocol_we,
  input  wire logic [PROTO_W-1:0] protocol_wdata,
  // input words
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic [15:0]        address,
  input  wire logic [7:0]         command,
  // result pairs
  output logic                    pair_valid,
  input  wire logic               pair_ready,
  output logic [DUR_W-1:0]        mark_us,
  output logic [DUR_W-1:0]        space_us,
  output logic                    last
);

  logic [PROTO_W-1:0] protocol;
  logic               seq_idle;
  logic               start;
  logic               push_valid;
  logic               push_ready;
  pair_t              push_pair;

  // hold the protocol; the user must make it change only between frames, as the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol <= PROTO_NEC;
    end else if (protocol_we) begin
      protocol <= protocol_wdata;
    end
  end

  // take a word only when idle; an unused protocol code drops it
  assign item_ready = seq_idle;
  assign start      = item_valid && seq_idle && (protocol != PROTO_NONE);

  irfe_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .protocol   (protocol),
    .address    (address),
    .command    (command),
    .idle       (seq_idle),
    .push_valid (push_valid),
    .push_pair  (push_pair),
    .push_ready (push_ready)
  );

  // the output register holds a pair; the sequencer advances when it is empty or its pair is taken
  irfe_out_buf u_out (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_pair  (push_pair),
    .push_ready (push_ready),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .mark_us    (mark_us),
    .space_us   (space_us),
    .last       (last)
  );

  // a dropped word must leave the encoder idle
  a_drop_stays_idle: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && protocol == PROTO_NONE |=> item_ready)
    else $error("encoder left idle on unused protocol code");

  // the sequencer produces nothing while idle
  a_idle_no_push: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !push_valid)
    else $error("pair pushed while sequencer idle");

  // handing over the final pair ends the frame
  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    push_valid && push_ready && push_pair.last |=> item_ready)
    else $error("sequencer busy after final pair");

endmodule
`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb - self-checking bench for the IR remote frame timing encoder
// Feeds address/command words under every protocol setting, predicts the
// mark/space pairs of each frame and compares every pair, field by field,
// against the oldest prediction. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import irfe_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_WORDS = 220;
  // cycles to wait after the last pair before touching the protocol register;
  // a word under the unused code makes no pair and leaves the block idle
  localparam int DRAIN_CYCLES = 64;
  // worst case is roughly 250 words x 34 pairs, each behind a random receiver stall; allow several times
  localparam int LIMIT_CYCLES = 800000;

  // --------------------------------------------------------------------------
  // Scoreboard: holds the protocol copy, builds the pairs each word should
  // produce and checks the pairs coming out of the block in order.
  // --------------------------------------------------------------------------
  class ir_pair_scoreboard;
    logic [PROTO_W-1:0] protocol;
    pair_t              pending_pairs[$];
    int                 mismatches;

    function new();
      protocol    = PROTO_NEC;
      mismatches  = 0;
    endfunction

    function void set_protocol(logic [PROTO_W-1:0] p);
      protocol = p;
    endfunction

    // RC5 half bit level: a 1 is space then mark, a 0 is mark then space
    function bit rc5_half_level(logic [13:0] frame, int h);
      bit b;
      b = frame[13 - h / 2];
      return (h % 2 == 1) ? b : !b;
    endfunction

    function void note_word(logic [15:0] addr, logic [7:0] cmd);
      logic [DUR_W-1:0] durs[$];
      logic [31:0]      nec_bits;
      logic [11:0]      sirc_bits;
      logic [13:0]      rc5_bits;
      int               h;
      int               run;
      bit               level;
      pair_t            p;
      case (protocol)
        PROTO_NEC: begin
          nec_bits = {~cmd, cmd, addr};
          durs.push_back(T_NEC_HDR_MARK);
          durs.push_back(T_NEC_HDR_SPACE);
          for (int i = 0; i < 32; i++) begin
            durs.push_back(T_NEC_SHORT);
            durs.push_back(nec_bits[i] ? T_NEC_LONG : T_NEC_SHORT);
          end
          durs.push_back(T_NEC_SHORT);
          durs.push_back(T_GAP);
        end
        PROTO_SIRC: begin
          sirc_bits = {addr[4:0], cmd[6:0]};
          durs.push_back(T_SIRC_HDR);
          durs.push_back(T_SIRC_UNIT);
          for (int i = 0; i < 12; i++) begin
            durs.push_back(sirc_bits[i] ? T_SIRC_ONE : T_SIRC_UNIT);
            durs.push_back(T_SIRC_UNIT);
          end
          durs.push_back(T_ZERO);
          durs.push_back(T_GAP);
        end
        PROTO_RC5: begin
          rc5_bits = 14'h3000 | {3'b000, addr[4:0], 6'b000000} | {8'h00, cmd[5:0]};
          // drop the leading idle half, then merge equal halves into runs
          h = 0;
          while (h < 28 && !rc5_half_level(rc5_bits, h))
            h++;
          level = 1'b1;
          run   = 0;
          for (; h < 28; h++) begin
            if (rc5_half_level(rc5_bits, h) == level) begin
              run += int'(T_RC5_HALF);
            end else begin
              durs.push_back(DUR_W'(run));
              run   = int'(T_RC5_HALF);
              level = !level;
            end
          end
          durs.push_back(DUR_W'(run));
          // a frame ending on a mark gets the closing gap
          if (level)
            durs.push_back(T_GAP);
        end
        default: ;  // unused code: no pairs
      endcase
      for (int k = 0; k < durs.size() / 2; k++) begin
        p.mark  = durs[2 * k];
        p.space = durs[2 * k + 1];
        p.last  = (k == durs.size() / 2 - 1);
        pending_pairs.push_back(p);
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_pair(logic [DUR_W-1:0] m, logic [DUR_W-1:0] s, logic l);
      pair_t want;
      if (pending_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected pair mark=%0d space=%0d last=%0b", m, s, l));
        return;
      end
      want = pending_pairs.pop_front();
      if (m !== want.mark)
        report_mismatch($sformatf("mark_us got %0d want %0d", m, want.mark));
      if (s !== want.space)
        report_mismatch($sformatf("space_us got %0d want %0d", s, want.space));
      if (l !== want.last)
        report_mismatch($sformatf("last got %0b want %0b", l, want.last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst;
  logic               protocol_we;
  logic [PROTO_W-1:0] protocol_wdata;
  logic               item_valid;
  logic               item_ready;
  logic [15:0]        address;
  logic [7:0]         command;
  logic               pair_valid;
  logic               pair_ready;
  logic [DUR_W-1:0]   mark_us;
  logic [DUR_W-1:0]   space_us;
  logic               last;

  ir_remote_frame_timing_encoder i_dut (
    .clk            (clk),
    .rst            (rst),
    .protocol_we    (protocol_we),
    .protocol_wdata (protocol_wdata),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .address        (address),
    .command        (command),
    .pair_valid     (pair_valid),
    .pair_ready     (pair_ready),
    .mark_us        (mark_us),
    .space_us       (space_us),
    .last           (last)
  );

  ir_pair_scoreboard sb;
  bit                sender_steady;    // no gaps between words while set
  bit                receiver_steady;  // no stalls on pairs while set

  always #(CLK_HALF) clk = ~clk;

  // --------------------------------------------------------------------------
  // Drivers. Inputs change on the falling edge, handshakes are sampled on the
  // rising edge.
  // --------------------------------------------------------------------------

  // Hold the word on the port until the block takes it, then log it.
  task send_word(logic [15:0] addr, logic [7:0] cmd);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    address    <= addr;
    command    <= cmd;
    do @(posedge clk); while (!item_ready);
    sb.note_word(addr, cmd);
  endtask

  // Drop valid, wait for every predicted pair, then let the block go idle.
  task settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending_pairs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Pulse the write enable for one cycle; call only while the block is idle.
  task write_protocol(logic [PROTO_W-1:0] p);
    @(negedge clk);
    protocol_we    <= 1'b1;
    protocol_wdata <= p;
    @(negedge clk);
    protocol_we    <= 1'b0;
    sb.set_protocol(p);
  endtask

  // Lean toward the field extremes now and then, full range otherwise.
  function logic [15:0] pick_address();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function logic [7:0] pick_command();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Pair receiver: stall a random number of cycles per pair, with stretches
  // of full-rate acceptance in between.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    while (rst !== 1'b0)
      @(negedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0)
        receiver_steady = !receiver_steady;
      stall = receiver_steady ? 0 : $urandom_range(0, 19);
      @(negedge clk);
      if (stall > 0) begin
        pair_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pair_ready <= 1'b1;
      do @(posedge clk); while (!pair_valid);
      sb.check_pair(mark_us, space_us, last);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [PROTO_W-1:0] proto;
    int                 words_sent;
    int                 n;
    sb              = new();
    clk             = 1'b0;
    rst             = 1'b1;
    protocol_we     = 1'b0;
    protocol_wdata  = PROTO_NEC;
    item_valid      = 1'b0;
    address         = 16'h0000;
    command         = 8'h00;
    pair_ready      = 1'b0;
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: NEC straight out of reset, all-zero, all-one and alternating bits
    send_word(16'h0000, 8'h00);
    send_word(16'hFFFF, 8'hFF);
    send_word(16'hAAAA, 8'h55);
    send_word(16'h5555, 8'hAA);
    settle();

    // SIRC: all-zero, all-one, used bits all set, then only the ignored upper bits set
    write_protocol(PROTO_SIRC);
    send_word(16'h0000, 8'h00);
    send_word(16'hFFFF, 8'hFF);
    send_word(16'h001F, 8'h7F);
    send_word(16'hFFE0, 8'h80);
    settle();

    // RC5: frames ending on a space (no gap) and on a mark (gap added)
    write_protocol(PROTO_RC5);
    send_word(16'h0000, 8'h00);
    send_word(16'hFFFF, 8'hFF);
    send_word(16'h001F, 8'h3F);
    send_word(16'h0015, 8'h2A);
    send_word(16'hFFE0, 8'hC0);
    settle();

    // Unused protocol code: words are taken but make no pairs
    write_protocol(PROTO_NONE);
    send_word(16'h0000, 8'h00);
    send_word(16'hFFFF, 8'hFF);
    settle();

    // Random phases: pick a protocol, run a burst of words, drain, repeat
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      proto = PROTO_W'($urandom_range(0, 3));
      write_protocol(proto);
      sender_steady = ($urandom_range(0, 3) == 0);
      n = (proto == PROTO_NONE) ? 3 : $urandom_range(8, 30);
      repeat (n) begin
        send_word(pick_address(), pick_command());
        if (proto != PROTO_NONE)
          words_sent++;
        // occasionally hold the sender until the block has caught up
        if ($urandom_range(0, 15) == 0)
          settle();
      end
      settle();
    end

    if (sb.mismatches == 0 && sb.pending_pairs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop if the block hangs or drops pairs
  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/irfe_pkg.sv
rtl/irfe_out_buf.sv
rtl/irfe_seq.sv
rtl/ir_remote_frame_timing_encoder.sv
bench/tb.sv
